### hdl/mi_pkg.sv
// ============================================================================
// mi_pkg
// Shared types and constants for the modular inverse core.
// ============================================================================
package mi_pkg;

    // Width of the signed input value.
    localparam int VALUE_W = 32;
    // Width of the inverse and gcd result fields.
    localparam int RESULT_W = 16;
    // Modulus held after reset.
    localparam int MODULUS_RESET = 31;

    // Sequencer states of the core.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } mi_state_t;

    // Command from the sequencer to the shared divider.
    typedef struct packed {
        logic start;
        logic wide;
    } mi_div_cmd_t;

    // Status from the shared divider back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } mi_div_sts_t;

endpackage

### hdl/mi_if.sv
// ============================================================================
// mi_if
// Valid/ready channel interfaces for operand, result and configuration.
// ============================================================================
interface mi_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface mi_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] inverse;
    logic [15:0] common_divisor;

    modport source (output valid, output inverse, output common_divisor, input ready);
    modport sink   (input valid, input inverse, input common_divisor, output ready);
endinterface

interface mi_cfg_if #(
    parameter int DATA_W = 16
);
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/mi_div_unit.sv
// ============================================================================
// mi_div_unit
// Shared restoring divider, one quotient bit per cycle, which also builds the
// product of the quotient and a signed coefficient by shift and add.
// ============================================================================
module mi_div_unit import mi_pkg::*; #(
    parameter int MOD_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mi_div_cmd_t                 cmd,
    input  logic [VALUE_W-1:0]          dividend,
    input  logic [MOD_WIDTH-1:0]        divisor,
    input  logic signed [MOD_WIDTH+1:0] coef,
    output mi_div_sts_t                 sts,
    output logic [MOD_WIDTH-1:0]        remainder,
    output logic signed [MOD_WIDTH+1:0] product
);

    localparam int CW    = MOD_WIDTH + 2;
    localparam int SHIFT = VALUE_W - MOD_WIDTH;
    localparam int CNT_W = $clog2(VALUE_W + 1);

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [VALUE_W-1:0]   num_reg,   num_next;
    logic [MOD_WIDTH-1:0] den_reg,   den_next;
    logic [MOD_WIDTH-1:0] rem_reg,   rem_next;
    logic signed [CW-1:0] coef_reg,  coef_next;
    logic signed [CW-1:0] prod_reg,  prod_next;

    logic [MOD_WIDTH:0]   trial;
    logic [MOD_WIDTH:0]   trial_diff;
    logic                 fits;

    always_comb
    begin
        trial      = {rem_reg, num_reg[VALUE_W-1]};
        trial_diff = trial - {1'b0, den_reg};
        fits       = (trial >= {1'b0, den_reg});

        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        coef_next  = coef_reg;
        prod_next  = prod_reg;

        if (cmd.start)
        begin
            busy_next = 1'b1;
            den_next  = divisor;
            rem_next  = '0;
            coef_next = coef;
            prod_next = '0;
            if (cmd.wide)
            begin
                num_next   = dividend;
                count_next = CNT_W'(VALUE_W);
            end
            else
            begin
                // A narrow operand is left-aligned so its top bit enters first.
                num_next   = dividend << SHIFT;
                count_next = CNT_W'(MOD_WIDTH);
            end
        end
        else if (busy_reg)
        begin
            num_next   = num_reg << 1;
            rem_next   = fits ? trial_diff[MOD_WIDTH-1:0] : trial[MOD_WIDTH-1:0];
            prod_next  = (prod_reg <<< 1) + (fits ? coef_reg : CW'(0));
            count_next = count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        coef_reg <= coef_next;
        prod_reg <= prod_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign remainder = rem_reg;
    assign product   = prod_reg;

`ifndef SYNTH
    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg)
        else $error("divider started while busy");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (count_reg != '0))
        else $error("divider busy with no steps left");

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a finished run");
`endif

endmodule

### hdl/modular_inverse_core.sv
// Each result takes a reduction of the operand and then k Euclid steps, where k is at
// most about 24 for a 16-bit modulus.
// Throughput: one item at a time; the next operand is taken once the result is registered.
// The time per item is set by the shared bit-serial divider, which works through the full operand
// width for the reduction and MOD_WIDTH bits for each Euclid quotient. A zero modulus skips the divider.
// Reset (rst_n, asynchronous, active low) idles the core and loads the modulus with 31.
// ============================================================================
// modular_inverse_core
// Modular inverse by the extended Euclidean algorithm on a shared divider.
// ============================================================================
module modular_inverse_core import mi_pkg::*; #(
    parameter int MOD_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    mi_in_if.sink       operand,
    mi_out_if.source    result,
    mi_cfg_if.sink      cfg
);

    localparam int CW = MOD_WIDTH + 2;

    // Sequencer and datapath registers. The modulus register is the only
    // configuration; everything else is per-item working state.
    mi_state_t            state_reg,     state_next;
    logic [MOD_WIDTH-1:0] mod_reg;
    logic                 neg_reg,       neg_next;
    logic [MOD_WIDTH-1:0] rem_old_reg,   rem_old_next;
    logic [MOD_WIDTH-1:0] rem_cur_reg,   rem_cur_next;
    logic signed [CW-1:0] co_old_reg,    co_old_next;
    logic signed [CW-1:0] co_cur_reg,    co_cur_next;
    logic                 out_valid_reg, out_valid_next;
    logic [RESULT_W-1:0]  inverse_reg,   inverse_next;
    logic [RESULT_W-1:0]  gcd_reg,       gcd_next;

    // Shared divider connections.
    mi_div_cmd_t          div_cmd;
    mi_div_sts_t          div_sts;
    logic [VALUE_W-1:0]   div_dividend;
    logic [MOD_WIDTH-1:0] div_divisor;
    logic signed [CW-1:0] div_coef;
    logic [MOD_WIDTH-1:0] div_rem;
    logic signed [CW-1:0] div_prod;

    // Helpers for the input reduction and the final fold of the coefficient.
    logic [VALUE_W-1:0]   value_mag;
    logic signed [CW-1:0] co_fold;
    logic                 accept;

    mi_div_unit #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (div_cmd),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .coef      (div_coef),
        .sts       (div_sts),
        .remainder (div_rem),
        .product   (div_prod)
    );

    // The modulus is always accepted; change it only while idle, as the core does not enforce this.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= MOD_WIDTH'(MODULUS_RESET);
        end
        else if (cfg.valid)
        begin
            mod_reg <= MOD_WIDTH'(cfg.data);
        end
    end

    assign operand.ready = (state_reg == ST_IDLE);
    assign accept        = operand.valid && operand.ready;

    // Magnitude of the signed operand. The most negative value maps to 2^31,
    // which is still correct as an unsigned 32-bit number.
    assign value_mag = operand.value[VALUE_W-1] ? VALUE_W'(-operand.value)
                                                : VALUE_W'(operand.value);

    // The last old coefficient lies within one modulus of zero, so a single
    // add brings a negative one into range.
    assign co_fold = co_old_reg[CW-1] ? (co_old_reg + CW'(mod_reg)) : co_old_reg;

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        rem_old_next   = rem_old_reg;
        rem_cur_next   = rem_cur_reg;
        co_old_next    = co_old_reg;
        co_cur_next    = co_cur_reg;
        out_valid_next = out_valid_reg;
        inverse_next   = inverse_reg;
        gcd_next       = gcd_reg;

        div_cmd        = '0;
        div_dividend   = value_mag;
        div_divisor    = mod_reg;
        div_coef       = co_cur_reg;

        // The output register empties as soon as the sink takes the item.
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next = operand.value[VALUE_W-1];
                    if (mod_reg == '0)
                    begin
                        // No reduction is possible: both fields come out as zero.
                        rem_old_next = '0;
                        co_old_next  = '0;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        // Reduce the magnitude mod m over the full operand width.
                        div_cmd.start = 1'b1;
                        div_cmd.wide  = 1'b1;
                        state_next    = ST_REDUCE;
                    end
                end
            end

            ST_REDUCE:
            begin
                if (div_sts.done)
                begin
                    // A negative operand with a non-zero remainder folds to m - r.
                    if (neg_reg && (div_rem != '0))
                    begin
                        rem_old_next = mod_reg - div_rem;
                    end
                    else
                    begin
                        rem_old_next = div_rem;
                    end
                    rem_cur_next = mod_reg;
                    co_old_next  = CW'(1);
                    co_cur_next  = '0;
                    state_next   = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (rem_cur_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    // One Euclid step: quotient of the two remainders, with the
                    // divider also forming quotient times the current coefficient.
                    div_dividend  = VALUE_W'(rem_old_reg);
                    div_divisor   = rem_cur_reg;
                    div_coef      = co_cur_reg;
                    div_cmd.start = 1'b1;
                    div_cmd.wide  = 1'b0;
                    state_next    = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    rem_old_next = rem_cur_reg;
                    rem_cur_next = div_rem;
                    co_old_next  = co_cur_reg;
                    co_cur_next  = co_old_reg - div_prod;
                    state_next   = ST_CHECK;
                end
            end

            ST_OUT:
            begin
                // Load the result once the output register is free or being emptied.
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    inverse_next   = RESULT_W'(co_fold[MOD_WIDTH-1:0]);
                    gcd_next       = RESULT_W'(rem_old_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        rem_old_reg <= rem_old_next;
        rem_cur_reg <= rem_cur_next;
        co_old_reg  <= co_old_next;
        co_cur_reg  <= co_cur_next;
        inverse_reg <= inverse_next;
        gcd_reg     <= gcd_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.inverse        = inverse_reg;
    assign result.common_divisor = gcd_reg;

`ifndef SYNTH
    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> ((state_reg == ST_REDUCE) || (state_reg == ST_DIV)))
        else $error("divider finished while the sequencer was not waiting");

    a_out_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_OUT) && result.valid && !result.ready) |=> (state_reg == ST_OUT))
        else $error("result overwritten before it was taken");

    a_wait_holds_divider: assert property (@(posedge clk) disable iff (!rst_n)
        (((state_reg == ST_REDUCE) || (state_reg == ST_DIV)) && !div_sts.done)
            |-> div_sts.busy)
        else $error("sequencer waiting on an idle divider");
`endif

endmodule
